/* rtl/core/radix_integer_to_text_core_defines.svh */
`ifndef RADIX_INTEGER_TO_TEXT_CORE_DEFINES_SVH
`define RADIX_INTEGER_TO_TEXT_CORE_DEFINES_SVH

// same-cycle implication
`define RITT_ASSERT_NOW(label, clk, rst, cond, check, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (check)) \
      else $error(msg);

// next-cycle implication
`define RITT_ASSERT_NEXT(label, clk, rst, cond, check, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (check)) \
      else $error(msg);

`endif

/* rtl/core/ritt_pkg.sv */
`default_nettype none

package ritt_pkg;

   localparam int VALUE_W    = 64;
   localparam int DIGIT_W    = 4;
   localparam int CHAR_W     = 8;
   localparam int COUNT_W    = 7;
   localparam int BITS_PER_STEP = 4;
   localparam int DIV_STEPS  = VALUE_W / BITS_PER_STEP;
   localparam int STEP_W     = $clog2(DIV_STEPS);
   localparam int SIGNED_W   = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

   localparam logic [4:0]  RADIX_RESET = 5'd10;
   localparam logic [31:0] SYM0_RESET  = 32'd858927408;
   localparam logic [31:0] SYM1_RESET  = 32'd926299444;
   localparam logic [31:0] SYM2_RESET  = 32'd1650538808;
   localparam logic [31:0] SYM3_RESET  = 32'd1717920931;

   typedef enum logic [2:0] {
      REG_RADIX = 3'd0,
      REG_SYM0  = 3'd1,
      REG_SYM1  = 3'd2,
      REG_SYM2  = 3'd3,
      REG_SYM3  = 3'd4
   } reg_index_type;

   typedef logic [3:0][31:0] symbols_type;

   typedef struct packed {
      logic [VALUE_W-1:0] magnitude;
      logic               negative;
   } job_type;

   function automatic logic [CHAR_W-1:0] symbol_of(symbols_type syms,
                                                    logic [DIGIT_W-1:0] digit);
      return syms[digit[3:2]][{digit[1:0], 3'b000} +: CHAR_W];
   endfunction

endpackage

`default_nettype wire

/* rtl/core/ritt_ram.sv */
`default_nettype none

module ritt_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/ritt_front.sv */
`default_nettype none

module ritt_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [ritt_pkg::VALUE_W-1:0]  req_tdata,
   input  wire logic                          req_tuser,
   output logic                               job_valid,
   input  wire logic                          job_ready,
   output ritt_pkg::job_type                  job
);

   ritt_pkg::job_type queue_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        fill_ff;

   ritt_pkg::job_type incoming;
   logic [ritt_pkg::SIGNED_W-1:0] low_word;
   logic [ritt_pkg::SIGNED_W-1:0] low_mag;
   logic push;
   logic pop;

   always_comb begin
      low_word = req_tdata[ritt_pkg::SIGNED_W-1:0];
      incoming.negative = req_tuser & low_word[ritt_pkg::SIGNED_W-1];
      low_mag = incoming.negative ? (~low_word + 1'b1) : low_word;
      if (req_tuser) begin
         incoming.magnitude = {{(ritt_pkg::VALUE_W-ritt_pkg::SIGNED_W){1'b0}}, low_mag};
      end else begin
         incoming.magnitude = req_tdata;
      end
   end

   assign req_tready = (fill_ff != 2'd2);
   assign job_valid  = (fill_ff != 2'd0);
   assign job        = queue_ff[rd_ptr_ff];
   assign push       = req_tvalid & req_tready;
   assign pop        = job_valid & job_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= incoming;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   fill_ff <= fill_ff + 2'd1;
            2'b01:   fill_ff <= fill_ff - 2'd1;
            default: fill_ff <= fill_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

/* rtl/core/ritt_back.sv */
`default_nettype none
`include "radix_integer_to_text_core_defines.svh"

module ritt_back #(
   parameter int MAX_DIGITS = 64,
   parameter int MAX_RADIX  = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 job_valid,
   output logic                                      job_ready,
   input  wire ritt_pkg::job_type                    job,
   input  wire logic [$clog2(MAX_RADIX+1)-1:0]       radix,
   input  wire ritt_pkg::symbols_type                syms,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [15:0]                               rsp_tdata,
   output logic                                      rsp_tlast
);

   localparam int ADDR_W  = $clog2(MAX_DIGITS);
   localparam int TOT_W   = $clog2(MAX_DIGITS+1);
   localparam int DIV_W   = ritt_pkg::DIGIT_W + 1;
   localparam int VALUE_W = ritt_pkg::VALUE_W;
   localparam int DIGIT_W = ritt_pkg::DIGIT_W;
   localparam int STEP_W  = ritt_pkg::STEP_W;
   localparam int COUNT_W = ritt_pkg::COUNT_W;
   localparam int CHAR_W  = ritt_pkg::CHAR_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_LOAD,
      ST_OUT
   } state_type;

   state_type           state_ff;
   logic [VALUE_W-1:0]  value_ff;
   logic [DIGIT_W-1:0]  rem_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [TOT_W-1:0]    total_ff;
   logic                neg_ff;
   logic [COUNT_W-1:0]  chars_ff;
   logic                rsp_valid_ff;
   logic [CHAR_W-1:0]   out_char_ff;
   logic [COUNT_W-1:0]  out_count_ff;
   logic                out_last_ff;

   logic [VALUE_W-1:0]  div_value;
   logic [DIGIT_W-1:0]  div_rem;
   logic [DIV_W-1:0]    trial;
   logic [DIV_W-1:0]    divisor;
   logic [TOT_W-1:0]    next_total;
   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [DIGIT_W-1:0]  ram_rd_data;

   // four quotient bits per cycle, restoring
   always_comb begin
      divisor   = DIV_W'(radix);
      div_value = value_ff;
      div_rem   = rem_ff;
      trial     = '0;
      for (int j = 0; j < ritt_pkg::BITS_PER_STEP; j++) begin
         trial     = {div_rem, div_value[VALUE_W-1]};
         div_value = {div_value[VALUE_W-2:0], 1'b0};
         if (trial >= divisor) begin
            trial        = trial - divisor;
            div_value[0] = 1'b1;
         end
         div_rem = trial[DIGIT_W-1:0];
      end
   end

   assign next_total  = total_ff + 1'b1;
   assign ram_wr_en   = (state_ff == ST_DIV) && (step_ff == STEP_W'(ritt_pkg::DIV_STEPS-1));
   assign ram_rd_addr = ADDR_W'(total_ff - 1'b1);

   ritt_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (MAX_DIGITS)
   ) u_digit_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (total_ff[ADDR_W-1:0]),
      .wr_data (div_rem),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign job_ready  = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {1'b0, out_count_ff, out_char_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  value_ff <= job.magnitude;
                  neg_ff   <= job.negative;
                  rem_ff   <= '0;
                  step_ff  <= '0;
                  total_ff <= '0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               value_ff <= div_value;
               rem_ff   <= ram_wr_en ? '0 : div_rem;
               step_ff  <= step_ff + 1'b1;
               if (ram_wr_en) begin
                  total_ff <= next_total;
                  if ((div_value == '0) || (next_total == TOT_W'(MAX_DIGITS))) begin
                     if (neg_ff) begin
                        out_char_ff  <= ritt_pkg::MINUS_CHAR;
                        out_count_ff <= COUNT_W'(1);
                        out_last_ff  <= 1'b0;
                        chars_ff     <= COUNT_W'(1);
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= ST_OUT;
                     end else begin
                        chars_ff <= '0;
                        state_ff <= ST_READ;
                     end
                  end
               end
            end
            ST_READ: begin
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               out_char_ff  <= ritt_pkg::symbol_of(syms, ram_rd_data);
               out_count_ff <= chars_ff + 1'b1;
               out_last_ff  <= (total_ff == TOT_W'(1));
               chars_ff     <= chars_ff + 1'b1;
               total_ff     <= total_ff - 1'b1;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_OUT;
            end
            ST_OUT: begin
               if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= out_last_ff ? ST_IDLE : ST_READ;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   `RITT_ASSERT_NOW(a_rem_below_radix, clock, reset, (state_ff == ST_DIV),
      ({1'b0, rem_ff} < divisor), "remainder not below radix")
   `RITT_ASSERT_NOW(a_total_bounded, clock, reset, 1'b1,
      (total_ff <= TOT_W'(MAX_DIGITS)), "digit total beyond store depth")
   `RITT_ASSERT_NOW(a_last_empties_store, clock, reset, (rsp_valid_ff && out_last_ff),
      (total_ff == '0), "last item with digits left")
   `RITT_ASSERT_NEXT(a_digit_counted, clock, reset, ram_wr_en,
      (total_ff == $past(next_total)), "digit written but not counted")

endmodule

`default_nettype wire

/* rtl/core/radix_integer_to_text_core.sv */
// channel   | dir | handshake            | payload
// req       | in  | req_tvalid/tready    | tdata: number; tuser: signed_int
// rsp       | out | rsp_tvalid/tready    | tdata: character, count; tlast: last
// csr       | in  | psel/penable/pwrite  | radix, four symbol registers
//
// one digit per division pass of the radix divider (4 quotient bits a cycle)
// each digit character then passes through the READ, LOAD and OUT states, holding in OUT while rsp stalls
// a 2-deep queue lets the front take new numbers while the divider is busy
// synchronous active-high reset clears control state and loads register defaults
`default_nettype none

module radix_integer_to_text_core #(
   parameter int MAX_DIGITS = 64,
   parameter int MAX_RADIX  = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [ritt_pkg::VALUE_W-1:0]      req_tdata,   // number[63:0]
   input  wire logic                              req_tuser,   // signed_int
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [15:0]                            rsp_tdata,   // character[7:0], count[14:8]
   output logic                                   rsp_tlast,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [ritt_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [ritt_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ritt_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready
);

   localparam int RADIX_W = $clog2(MAX_RADIX+1);

   logic [RADIX_W-1:0]     radix_ff;
   ritt_pkg::symbols_type  syms_ff;

   ritt_pkg::reg_index_type csr_index;
   logic                    csr_write;
   logic [4:0]              radix_wr;
   logic [RADIX_W-1:0]      radix_in;

   logic              job_valid;
   logic              job_ready;
   ritt_pkg::job_type job;

   assign csr_pready = 1'b1;
   assign csr_index  = ritt_pkg::reg_index_type'(csr_paddr[4:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign radix_wr   = csr_pwdata[4:0];

   always_comb begin
      if (radix_wr < 5'd2) begin
         radix_in = RADIX_W'(2);
      end else if (radix_wr > 5'(MAX_RADIX)) begin
         radix_in = RADIX_W'(MAX_RADIX);
      end else begin
         radix_in = RADIX_W'(radix_wr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff   <= RADIX_W'(ritt_pkg::RADIX_RESET);
         syms_ff[0] <= ritt_pkg::SYM0_RESET;
         syms_ff[1] <= ritt_pkg::SYM1_RESET;
         syms_ff[2] <= ritt_pkg::SYM2_RESET;
         syms_ff[3] <= ritt_pkg::SYM3_RESET;
      end else if (csr_write) begin
         case (csr_index)
            ritt_pkg::REG_RADIX: radix_ff   <= radix_in;
            ritt_pkg::REG_SYM0:  syms_ff[0] <= csr_pwdata;
            ritt_pkg::REG_SYM1:  syms_ff[1] <= csr_pwdata;
            ritt_pkg::REG_SYM2:  syms_ff[2] <= csr_pwdata;
            ritt_pkg::REG_SYM3:  syms_ff[3] <= csr_pwdata;
            default:             radix_ff   <= radix_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         ritt_pkg::REG_RADIX: csr_prdata = ritt_pkg::CSR_DATA_W'(radix_ff);
         ritt_pkg::REG_SYM0:  csr_prdata = syms_ff[0];
         ritt_pkg::REG_SYM1:  csr_prdata = syms_ff[1];
         ritt_pkg::REG_SYM2:  csr_prdata = syms_ff[2];
         ritt_pkg::REG_SYM3:  csr_prdata = syms_ff[3];
         default:             csr_prdata = '0;
      endcase
   end

   ritt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .job        (job)
   );

   ritt_back #(
      .MAX_DIGITS (MAX_DIGITS),
      .MAX_RADIX  (MAX_RADIX)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .job        (job),
      .radix      (radix_ff),
      .syms       (syms_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
